@@ sv/rtpts_pkg.sv @@
// Shared types and constants of the RTP send-timestamp extractor.
package rtpts_pkg;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_VERSION = 3'd2;
  localparam logic [2:0] ST_NO_EXT  = 3'd3;
  localparam logic [2:0] ST_PROFILE = 3'd4;
  localparam logic [2:0] ST_OVERRUN = 3'd5;

  localparam logic [15:0] EXT_PROFILE     = 16'hBEDE;
  localparam logic [1:0]  RTP_VERSION     = 2'd2;
  localparam logic [6:0]  FIXED_HDR_BYTES = 7'd12;
  localparam logic [6:0]  EXT_HDR_BYTES   = 7'd4;
  localparam logic [3:0]  TS_BYTES        = 4'd8;
  localparam logic [3:0]  TS_LEN_CODE     = 4'd7;
  localparam logic [23:0] PKT_BITS_MAX    = 24'd524280;

  // Register map
  localparam logic REG_TS_ID = 1'b0;
  localparam logic [3:0] TS_ID_RESET = 4'd1;

  // Hand-off queue between parser and result stage
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  typedef struct packed {
    logic [7:0]  packet_byte;
    logic        last_byte;
    logic [63:0] arrival_us;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         parse_status;
    logic [15:0]        sequence_number;
    logic [63:0]        sent_time_us;
    logic [63:0]        received_time_us;
    logic signed [63:0] one_way_delay_us;
    logic [18:0]        packet_bits;
    logic [63:0]        total_bits;
  } out_item_t;

  // One parsed packet, as handed from the parser to the result stage
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] sequence_number;
    logic [63:0] sent_time_us;
    logic [63:0] received_time_us;
  } rec_t;

endpackage

@@ sv/rtpts_front.sv @@
// Byte-serial RTP header and one-byte extension parser.
module rtpts_front #(
  parameter int PACKET_COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_take,
  input  rtpts_pkg::in_item_t          in_item,
  input  logic [3:0]                   ts_id,
  output logic                         rec_push,
  output rtpts_pkg::rec_t              rec,
  output logic [PACKET_COUNT_BITS-1:0] rec_cnt
);
  import rtpts_pkg::*;

  localparam int CW = PACKET_COUNT_BITS;
  localparam int LW = ((CW > 19) ? CW : 19) + 1;

  localparam logic [1:0] PH_FIXED  = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_WALK   = 2'd2;
  localparam logic [1:0] PH_IDLE   = 2'd3;

  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    vf_r, vf_nxt;
  logic [15:0]   seq_r, seq_nxt;
  logic [15:0]   prof_r, prof_nxt;
  logic [17:0]   extlen_r, extlen_nxt;
  logic [17:0]   extoff_r, extoff_nxt;
  logic [3:0]    rem_r, rem_nxt;
  logic          stop_r, stop_nxt;
  logic [63:0]   shift_r, shift_nxt;
  logic [63:0]   found_r, found_nxt;
  logic [63:0]   arr_r, arr_nxt;

  logic [7:0]    b;
  logic          first;
  logic [6:0]    hl;
  logic [2:0]    lane;
  logic [18:0]   elem_end;
  logic [LW-1:0] n_ext;
  logic [LW-1:0] hdr_end;
  logic [2:0]    status;

  always_comb begin
    b          = in_item.packet_byte;
    first      = (cnt_r == '0);
    cnt_nxt    = (cnt_r == {CW{1'b1}}) ? cnt_r : cnt_r + CW'(1);
    vf_nxt     = first ? b : vf_r;
    arr_nxt    = first ? in_item.arrival_us : arr_r;
    hl         = FIXED_HDR_BYTES + {1'b0, vf_nxt[3:0], 2'b00};
    lane       = 3'(TS_BYTES - rem_r);
    elem_end   = 19'(extoff_r) + 19'(b[3:0]) + 19'd2;
    phase_nxt  = phase_r;
    seq_nxt    = seq_r;
    prof_nxt   = prof_r;
    extlen_nxt = extlen_r;
    extoff_nxt = extoff_r;
    rem_nxt    = rem_r;
    stop_nxt   = stop_r;
    shift_nxt  = shift_r;
    found_nxt  = found_r;

    if (cnt_r == CW'(2)) begin
      seq_nxt = {b, 8'h00};
    end else if (cnt_r == CW'(3)) begin
      seq_nxt = {seq_r[15:8], b};
    end

    unique case (phase_r)
      PH_FIXED: begin
        if (cnt_r == CW'(11)) begin
          phase_nxt = (vf_r[7:6] == RTP_VERSION && vf_r[4]) ? PH_HEADER : PH_IDLE;
        end
      end
      PH_HEADER: begin
        if (cnt_r == CW'(hl)) begin
          prof_nxt = {b, 8'h00};
        end else if (cnt_r == CW'(hl + 7'd1)) begin
          prof_nxt = {prof_r[15:8], b};
        end else if (cnt_r == CW'(hl + 7'd2)) begin
          extlen_nxt = {2'b00, b, 8'h00};
        end else if (cnt_r == CW'(hl + 7'd3)) begin
          // length is given in 32-bit words
          extlen_nxt = {extlen_r[15:8], b, 2'b00};
          extoff_nxt = '0;
          phase_nxt  = (prof_r == EXT_PROFILE && extlen_nxt != '0) ? PH_WALK : PH_IDLE;
        end
      end
      PH_WALK: begin
        if (rem_r != '0) begin
          shift_nxt[{lane, 3'b000} +: 8] = b;
          rem_nxt = rem_r - 4'd1;
          if (rem_r == 4'd1) begin
            found_nxt = shift_nxt;
          end
        end else if (!stop_r && b != 8'h00) begin
          // zero bytes are padding; anything else is an element header
          if (elem_end > {1'b0, extlen_r}) begin
            stop_nxt = 1'b1;
          end else if (b[7:4] == ts_id && b[3:0] == TS_LEN_CODE) begin
            rem_nxt   = TS_BYTES;
            shift_nxt = '0;
          end else begin
            stop_nxt = 1'b1;
          end
        end
        extoff_nxt = extoff_r + 18'd1;
        if (extoff_nxt >= extlen_r) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: ;
    endcase

    // Judge the packet on the state it would hold after this byte
    n_ext   = LW'(cnt_nxt);
    hdr_end = LW'(hl) + LW'(EXT_HDR_BYTES);
    if (n_ext < LW'(FIXED_HDR_BYTES)) begin
      status = ST_SHORT;
    end else if (vf_nxt[7:6] != RTP_VERSION) begin
      status = ST_VERSION;
    end else if (!vf_nxt[4]) begin
      status = ST_OK;
    end else if (n_ext < hdr_end) begin
      status = ST_NO_EXT;
    end else if (prof_nxt != EXT_PROFILE) begin
      status = ST_PROFILE;
    end else if (n_ext < hdr_end + LW'(extlen_nxt)) begin
      status = ST_OVERRUN;
    end else begin
      status = ST_OK;
    end
  end

  assign rec_push             = in_take && in_item.last_byte;
  assign rec.status           = status;
  assign rec.sequence_number  = seq_nxt;
  assign rec.sent_time_us     = (status == ST_OK) ? found_nxt : 64'd0;
  assign rec.received_time_us = arr_nxt;
  assign rec_cnt              = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (in_take && in_item.last_byte)) begin
      phase_r  <= PH_FIXED;
      cnt_r    <= '0;
      vf_r     <= '0;
      seq_r    <= '0;
      prof_r   <= '0;
      extlen_r <= '0;
      extoff_r <= '0;
      rem_r    <= '0;
      stop_r   <= 1'b0;
      shift_r  <= '0;
      found_r  <= '0;
      arr_r    <= '0;
    end else if (in_take) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      vf_r     <= vf_nxt;
      seq_r    <= seq_nxt;
      prof_r   <= prof_nxt;
      extlen_r <= extlen_nxt;
      extoff_r <= extoff_nxt;
      rem_r    <= rem_nxt;
      stop_r   <= stop_nxt;
      shift_r  <= shift_nxt;
      found_r  <= found_nxt;
      arr_r    <= arr_nxt;
    end
  end

endmodule

@@ sv/rtpts_queue.sv @@
// Short FIFO of parsed packet records between parser and result stage.
module rtpts_queue #(
  parameter int CNT_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  rtpts_pkg::rec_t  wr_rec,
  input  logic [CNT_W-1:0] wr_cnt,
  input  logic             rd_en,
  output logic             rd_valid,
  output rtpts_pkg::rec_t  rd_rec,
  output logic [CNT_W-1:0] rd_cnt,
  output logic             q_full
);
  import rtpts_pkg::*;

  rec_t             rec_mem [Q_DEPTH];
  logic [CNT_W-1:0] cnt_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   fill_r, fill_nxt;

  always_comb begin
    fill_nxt = fill_r;
    if (wr_en && !rd_en) begin
      fill_nxt = fill_r + (Q_PTR_W + 1)'(1);
    end else if (rd_en && !wr_en) begin
      fill_nxt = fill_r - (Q_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_mem[wr_ptr_r] <= wr_rec;
      cnt_mem[wr_ptr_r] <= wr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      fill_r <= fill_nxt;
    end
  end

  assign rd_valid = (fill_r != '0);
  assign rd_rec   = rec_mem[rd_ptr_r];
  assign rd_cnt   = cnt_mem[rd_ptr_r];
  assign q_full   = (fill_r == (Q_PTR_W + 1)'(Q_DEPTH));

endmodule

@@ sv/rtpts_back.sv @@
// Result stage: delay, packet bits, running bit total and output register.
module rtpts_back #(
  parameter int CNT_W = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  rtpts_pkg::rec_t       q_rec,
  input  logic [CNT_W-1:0]      q_cnt,
  output logic                  q_take,
  input  logic                  pop,
  output logic                  out_valid,
  output rtpts_pkg::out_item_t  out_item
);
  import rtpts_pkg::*;

  logic [CNT_W+2:0] bits;
  logic [23:0]      bits_wide;
  logic [63:0]      total_r, total_nxt;
  logic             valid_r;
  out_item_t        out_r;

  assign q_take    = q_valid && (!valid_r || pop);
  assign bits      = {q_cnt, 3'b000};
  assign bits_wide = 24'(bits);
  assign total_nxt = total_r + 64'(bits);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      total_r <= '0;
    end else if (q_take) begin
      valid_r <= 1'b1;
      total_r <= total_nxt;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      out_r.parse_status     <= q_rec.status;
      out_r.sequence_number  <= q_rec.sequence_number;
      out_r.sent_time_us     <= q_rec.sent_time_us;
      out_r.received_time_us <= q_rec.received_time_us;
      out_r.one_way_delay_us <= q_rec.received_time_us - q_rec.sent_time_us;
      // clamp the reported length, but keep the full count in the total
      out_r.packet_bits      <= (bits_wide > PKT_BITS_MAX) ? PKT_BITS_MAX[18:0]
                                                           : bits_wide[18:0];
      out_r.total_bits       <= total_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = out_r;

endmodule

@@ sv/rtp_send_timestamp_extractor.sv @@
// Top level of the RTP send-timestamp extractor.
//
//   channel   direction  handshake                  payload
//   input     in         push / full                in_item   (one packet byte)
//   result    out        empty / pop                out_item  (one per packet)
//   config    in/out     psel penable pwrite pready timestamp element ID at 0x0
//
// One byte is taken every cycle while full is low; the parser never stalls on its own.
// A result passes the record queue and the output register on its way to out_item.
// A four-entry record queue parts parser and result stage; full rises only
// when it holds four packets waiting behind a stalled result.
// Reset is synchronous and active low.
module rtp_send_timestamp_extractor #(
  parameter int PACKET_COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  rtpts_pkg::in_item_t  in_item,
  output logic                 empty,
  input  logic                 pop,
  output rtpts_pkg::out_item_t out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rtpts_pkg::*;

  logic [3:0]                   ts_id_r;
  logic                         in_take;
  logic                         rec_push;
  rec_t                         rec;
  logic [PACKET_COUNT_BITS-1:0] rec_cnt;
  logic                         q_valid;
  logic                         q_take;
  rec_t                         q_rec;
  logic [PACKET_COUNT_BITS-1:0] q_cnt;
  logic                         q_full;
  logic                         out_valid;

  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_TS_ID) ? {28'd0, ts_id_r} : 32'd0;
  assign in_take = push && !q_full;
  assign full    = q_full;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_id_r <= TS_ID_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TS_ID) begin
      ts_id_r <= pwdata[3:0];
    end
  end

  rtpts_front #(
    .PACKET_COUNT_BITS (PACKET_COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (in_take),
    .in_item  (in_item),
    .ts_id    (ts_id_r),
    .rec_push (rec_push),
    .rec      (rec),
    .rec_cnt  (rec_cnt)
  );

  rtpts_queue #(
    .CNT_W (PACKET_COUNT_BITS)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (rec_push),
    .wr_rec   (rec),
    .wr_cnt   (rec_cnt),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_rec   (q_rec),
    .rd_cnt   (q_cnt),
    .q_full   (q_full)
  );

  rtpts_back #(
    .CNT_W (PACKET_COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rec     (q_rec),
    .q_cnt     (q_cnt),
    .q_take    (q_take),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

@@ sv/rtpts_checker.sv @@
// Port-level checks for the RTP send-timestamp extractor, with its bind.
module rtpts_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 empty,
  input logic                 pop,
  input rtpts_pkg::out_item_t out_item,
  input logic                 psel,
  input logic                 penable,
  input logic                 pwrite,
  input logic [2:0]           paddr,
  input logic [31:0]          pwdata,
  input logic [31:0]          prdata
);
  import rtpts_pkg::*;

  // a waiting result holds until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("result changed while waiting");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_item.parse_status == ST_OK || out_item.parse_status == ST_SHORT ||
                out_item.parse_status == ST_VERSION || out_item.parse_status == ST_NO_EXT ||
                out_item.parse_status == ST_PROFILE || out_item.parse_status == ST_OVERRUN))
    else $error("status code out of range");

  a_bits_whole: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_item.packet_bits[2:0] == 3'd0 && out_item.packet_bits != 19'd0))
    else $error("packet bits not a whole non-zero byte count");

  a_reject_no_time: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.parse_status != ST_OK) |->
      (out_item.sent_time_us == 64'd0 &&
       out_item.one_way_delay_us == out_item.received_time_us))
    else $error("rejected packet carries a send time");

  a_reg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr[2] == REG_TS_ID) |=>
      (paddr[2] != REG_TS_ID || prdata[3:0] == $past(pwdata[3:0])))
    else $error("element ID register did not take the write");

endmodule

bind rtp_send_timestamp_extractor rtpts_checker u_rtpts_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata)
);

@@ tb/sv/rtp_send_timestamp_extractor_tb.sv @@
// Self-checking testbench of the RTP send-timestamp extractor: stimulus and predictor.
module rtp_send_timestamp_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtpts_pkg::*;

  localparam int PKT_CNT_W = 16;
  localparam logic [PKT_CNT_W-1:0] CNT_MAX = {PKT_CNT_W{1'b1}};
  localparam logic [2:0] TS_ID_ADDR = {REG_TS_ID, 2'b00};
  localparam logic [2:0] SPARE_ADDR = {~REG_TS_ID, 2'b00};
  localparam int N_DIRECTED = 23;

  typedef enum logic [1:0] {PH_FIXED_HDR, PH_EXT_HDR, PH_ELEMENTS, PH_SKIP} phase_e;
  typedef enum logic [1:0] {CFG_KEEP, CFG_TS_ID, CFG_SPARE} cfg_op_e;

  // One packet to play: header fields, extension layout and optional typed expectation
  typedef struct packed {
    cfg_op_e     cfg_op;
    logic [3:0]  cfg_val;
    logic [7:0]  b0;
    logic [15:0] seq;
    logic [15:0] profile;
    logic [15:0] ext_words;
    logic [3:0]  n_pad;
    logic [7:0]  elem_hdr;
    logic [63:0] ts;
    logic        dup;
    logic [16:0] payload;
    logic [16:0] cut;
    logic [63:0] arrival;
    logic        has_exp;
    logic [2:0]  exp_status;
    logic [63:0] exp_sent;
  } pkt_spec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rtp_send_timestamp_extractor #(.PACKET_COUNT_BITS(PKT_CNT_W)) dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Parser state of the predictor
  phase_e                ph;
  logic [PKT_CNT_W-1:0]  n_bytes;
  logic [7:0]            vf;
  logic [15:0]           seq_q;
  logic [15:0]           prof_q;
  logic [17:0]           ext_len;
  logic [17:0]           ext_pos;
  logic [4:0]            elem_left;
  logic                  elem_ts;
  logic                  walk_done;
  logic [63:0]           ts_acc;
  logic [63:0]           ts_seen;
  logic [63:0]           arrival_q;
  logic [63:0]           bits_sum;
  logic [3:0]            ts_id_cfg;

  out_item_t   pending_reports[$];
  logic [7:0]  pkt_bytes[$];
  pkt_spec_t   directed_pkts [N_DIRECTED];
  out_item_t   want;
  int          err_count = 0;
  int unsigned cyc = 0;
  logic        quiet;

  // Recurring stretch in which neither side idles
  assign quiet = (cyc % 4000) < 800;

  task automatic clear_packet_state();
    ph = PH_FIXED_HDR;
    n_bytes = '0;
    vf = '0;
    seq_q = '0;
    prof_q = '0;
    ext_len = '0;
    ext_pos = '0;
    elem_left = '0;
    elem_ts = 1'b0;
    walk_done = 1'b0;
    ts_acc = '0;
    ts_seen = '0;
    arrival_q = '0;
  endtask

  task automatic reset_model();
    ts_id_cfg = TS_ID_RESET;
    bits_sum = '0;
    clear_packet_state();
  endtask

  // Advance the parser by one accepted byte; rep is valid when the byte ends a packet
  task automatic rtp_parse_byte(input in_item_t it, output out_item_t rep);
    logic [7:0]           b;
    logic [PKT_CNT_W-1:0] i;
    logic [4:0]           len;
    logic [2:0]           st;
    logic [63:0]          sent;
    int unsigned          hl;
    int unsigned          n;
    b = it.packet_byte;
    i = n_bytes;
    rep = '0;
    if (i == 0) arrival_q = it.arrival_us;
    if (i == 0) vf = b;
    else if (i == 2) seq_q = {b, 8'h00};
    else if (i == 3) seq_q = seq_q | 16'(b);
    hl = FIXED_HDR_BYTES + 4 * vf[3:0];
    case (ph)
      PH_FIXED_HDR: begin
        if (i == FIXED_HDR_BYTES - 1)
          ph = (vf[7:6] == RTP_VERSION && vf[4]) ? PH_EXT_HDR : PH_SKIP;
      end
      PH_EXT_HDR: begin
        if (i == hl) prof_q = {b, 8'h00};
        else if (i == hl + 1) prof_q = prof_q | 16'(b);
        else if (i == hl + 2) ext_len = {2'b00, b, 8'h00};
        else if (i == hl + 3) begin
          ext_len = 18'((ext_len | 18'(b)) * 4);
          ext_pos = '0;
          ph = (prof_q == EXT_PROFILE && ext_len != 0) ? PH_ELEMENTS : PH_SKIP;
        end
      end
      PH_ELEMENTS: begin
        if (elem_left != 0) begin
          // timestamp bytes arrive least significant first
          if (elem_ts) ts_acc = ts_acc | (64'(b) << (8 * ((8 - elem_left) & 7)));
          elem_left = elem_left - 1'b1;
          if (elem_left == 0 && elem_ts) begin
            ts_seen = ts_acc;
            elem_ts = 1'b0;
          end
        end else if (!walk_done && b != 8'h00) begin
          len = {1'b0, b[3:0]} + 5'd1;
          if (ext_pos + 1 + len > ext_len) walk_done = 1'b1;
          else if (b[7:4] == ts_id_cfg && len == TS_BYTES) begin
            elem_left = 5'd8;
            elem_ts = 1'b1;
            ts_acc = '0;
          end else walk_done = 1'b1;
        end
        ext_pos = ext_pos + 1'b1;
        if (ext_pos >= ext_len) ph = PH_SKIP;
      end
      default: ;
    endcase
    if (n_bytes != CNT_MAX) n_bytes = n_bytes + 1'b1;
    if (it.last_byte) begin
      n = n_bytes;
      if (n < FIXED_HDR_BYTES) st = ST_SHORT;
      else if (vf[7:6] != RTP_VERSION) st = ST_VERSION;
      else if (!vf[4]) st = ST_OK;
      else if (n < hl + EXT_HDR_BYTES) st = ST_NO_EXT;
      else if (prof_q != EXT_PROFILE) st = ST_PROFILE;
      else if (n < hl + EXT_HDR_BYTES + ext_len) st = ST_OVERRUN;
      else st = ST_OK;
      sent = (st == ST_OK) ? ts_seen : '0;
      bits_sum = bits_sum + 64'(n) * 8;
      rep.parse_status = st;
      rep.sequence_number = seq_q;
      rep.sent_time_us = sent;
      rep.received_time_us = arrival_q;
      rep.one_way_delay_us = arrival_q - sent;
      rep.packet_bits = (n * 8 > PKT_BITS_MAX) ? PKT_BITS_MAX[18:0] : 19'(n * 8);
      rep.total_bits = bits_sum;
      clear_packet_state();
    end
  endtask

  task automatic assemble_packet(input pkt_spec_t s);
    int start;
    pkt_bytes.delete();
    pkt_bytes.push_back(s.b0);
    pkt_bytes.push_back(8'($urandom));
    pkt_bytes.push_back(s.seq[15:8]);
    pkt_bytes.push_back(s.seq[7:0]);
    // RTP timestamp, SSRC and the CSRC list
    repeat (8 + 4 * s.b0[3:0]) pkt_bytes.push_back(8'($urandom));
    if (s.b0[4]) begin
      pkt_bytes.push_back(s.profile[15:8]);
      pkt_bytes.push_back(s.profile[7:0]);
      pkt_bytes.push_back(s.ext_words[15:8]);
      pkt_bytes.push_back(s.ext_words[7:0]);
      start = pkt_bytes.size();
      repeat (s.n_pad) pkt_bytes.push_back(8'h00);
      if (s.elem_hdr != 8'h00) begin
        pkt_bytes.push_back(s.elem_hdr);
        for (int k = 0; k < 8; k++) pkt_bytes.push_back(s.ts[8*k +: 8]);
        if (s.dup) begin
          pkt_bytes.push_back(s.elem_hdr);
          for (int k = 0; k < 8; k++) pkt_bytes.push_back(~s.ts[8*k +: 8]);
        end
      end
      // pad or trim the body to the declared extension length
      while (pkt_bytes.size() - start < 4 * s.ext_words) pkt_bytes.push_back(8'h00);
      while (pkt_bytes.size() - start > 4 * s.ext_words) void'(pkt_bytes.pop_back());
    end
    repeat (s.payload) pkt_bytes.push_back(8'($urandom));
    if (s.cut != 0)
      while (pkt_bytes.size() > s.cut) void'(pkt_bytes.pop_back());
  endtask

  // Hold the request until the block takes it
  task automatic offer_byte(input in_item_t it);
    while (!quiet && $urandom_range(0, 99) < 20) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic play_packet(input pkt_spec_t s);
    in_item_t  it;
    out_item_t rep;
    assemble_packet(s);
    foreach (pkt_bytes[k]) begin
      it.packet_byte = pkt_bytes[k];
      it.last_byte = (k == pkt_bytes.size() - 1);
      it.arrival_us = (k == 0) ? s.arrival : {$urandom, $urandom};
      offer_byte(it);
      rtp_parse_byte(it, rep);
    end
    if (s.has_exp) begin
      rep.parse_status = s.exp_status;
      rep.sent_time_us = s.exp_sent;
      rep.one_way_delay_us = rep.received_time_us - s.exp_sent;
    end
    pending_reports.push_back(rep);
  endtask

  task automatic cfg_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (!wr && prdata !== {28'd0, ts_id_cfg}) begin
      $error("prdata: expected %0h, got %0h", {28'd0, ts_id_cfg}, prdata);
      err_count++;
    end
    if (wr && addr[2] == REG_TS_ID) ts_id_cfg = wdata[3:0];
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drain, let the pipeline empty, then write and read back
  task automatic apply_cfg(input cfg_op_e op, input logic [3:0] val);
    if (op != CFG_KEEP) begin
      push <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      cfg_access(1'b1, (op == CFG_TS_ID) ? TS_ID_ADDR : SPARE_ADDR, {28'($urandom), val});
      cfg_access(1'b0, TS_ID_ADDR, '0);
    end
  endtask

  function automatic pkt_spec_t random_spec();
    pkt_spec_t s;
    s = '0;
    s.cfg_op = CFG_KEEP;
    s.b0 = {2'b10, 1'($urandom), 1'b1, 4'($urandom_range(0, 3))};
    if ($urandom_range(0, 9) == 0) s.b0[3:0] = 4'hF;
    s.seq = 16'($urandom);
    s.profile = EXT_PROFILE;
    s.ext_words = 16'($urandom_range(1, 6));
    s.n_pad = 4'($urandom_range(0, 3));
    s.elem_hdr = {ts_id_cfg, TS_LEN_CODE};
    s.ts = {$urandom, $urandom};
    s.dup = ($urandom_range(0, 3) == 0);
    s.payload = 17'($urandom_range(0, 8));
    s.arrival = {$urandom, $urandom};
    // a fifth of the packets are broken in one place
    if ($urandom_range(0, 99) < 20) begin
      case ($urandom_range(0, 5))
        0: s.b0 = 8'($urandom);
        1: s.profile = 16'($urandom);
        2: s.elem_hdr = 8'($urandom);
        3: s.cut = 17'($urandom_range(1, 40));
        4: begin
          s.ext_words = 16'($urandom_range(0, 12));
          s.cut = 17'($urandom_range(1, 64));
        end
        default: s.b0[4] = 1'b0;
      endcase
    end
    return s;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    cyc <= cyc + 1;
    pop <= rst_n && (quiet || $urandom_range(0, 99) >= 20);
    if (rst_n && pop && !empty) begin
      if (pending_reports.size() == 0) begin
        $error("result with no packet waiting");
        err_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("parse_status", want.parse_status, out_item.parse_status);
        check_field("sequence_number", want.sequence_number, out_item.sequence_number);
        check_field("sent_time_us", want.sent_time_us, out_item.sent_time_us);
        check_field("received_time_us", want.received_time_us, out_item.received_time_us);
        check_field("one_way_delay_us", want.one_way_delay_us, out_item.one_way_delay_us);
        check_field("packet_bits", want.packet_bits, out_item.packet_bits);
        check_field("total_bits", want.total_bits, out_item.total_bits);
      end
    end
  end

  initial begin
    pkt_spec_t   s;
    cfg_op_e     op;
    logic [3:0]  id_val;
    int unsigned rnd_bytes;
    int unsigned rnd_pkts;
    reset_model();
    directed_pkts = '{
      // good packet, timestamp element with the reset ID
      '{CFG_KEEP, 4'h0, 8'h90, 16'h1234, EXT_PROFILE, 16'd3, 4'd0, 8'h17,
        64'h0123_4567_89AB_CDEF, 1'b0, 17'd4, 17'd0, 64'd1000,
        1'b1, ST_OK, 64'h0123_4567_89AB_CDEF},
      // under twelve bytes
      '{CFG_KEEP, 4'h0, 8'h90, 16'h0001, EXT_PROFILE, 16'd3, 4'd0, 8'h17,
        64'h1, 1'b0, 17'd0, 17'd5, 64'd5, 1'b1, ST_SHORT, 64'h0},
      '{CFG_KEEP, 4'h0, 8'h90, 16'h0002, EXT_PROFILE, 16'd3, 4'd0, 8'h17,
        64'h1, 1'b0, 17'd0, 17'd1, 64'd6, 1'b1, ST_SHORT, 64'h0},
      '{CFG_KEEP, 4'h0, 8'h90, 16'h0003, EXT_PROFILE, 16'd3, 4'd0, 8'h17,
        64'h1, 1'b0, 17'd0, 17'd11, 64'd7, 1'b1, ST_SHORT, 64'h0},
      // versions 1, 3 and 0
      '{CFG_KEEP, 4'h0, 8'h50, 16'h0004, EXT_PROFILE, 16'd3, 4'd0, 8'h17,
        64'h1, 1'b0, 17'd0, 17'd0, 64'd8, 1'b1, ST_VERSION, 64'h0},
      '{CFG_KEEP, 4'h0, 8'hD0, 16'h0005, EXT_PROFILE, 16'd3, 4'd0, 8'h17,
        64'h1, 1'b0, 17'd0, 17'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_VERSION, 64'h0},
      '{CFG_KEEP, 4'h0, 8'h00, 16'h0006, EXT_PROFILE, 16'd3, 4'd0, 8'h17,
        64'h1, 1'b0, 17'd0, 17'd0, 64'd9, 1'b1, ST_VERSION, 64'h0},
      // no extension bit
      '{CFG_KEEP, 4'h0, 8'h80, 16'h0007, EXT_PROFILE, 16'd3, 4'd0, 8'h17,
        64'h1, 1'b0, 17'd3, 17'd0, 64'd10, 1'b1, ST_OK, 64'h0},
      // ends inside the extension header, wrong profile, extension cut short
      '{CFG_KEEP, 4'h0, 8'h90, 16'h0008, EXT_PROFILE, 16'd3, 4'd0, 8'h17,
        64'h1, 1'b0, 17'd0, 17'd14, 64'd11, 1'b1, ST_NO_EXT, 64'h0},
      '{CFG_KEEP, 4'h0, 8'h90, 16'h0009, 16'h1000, 16'd3, 4'd0, 8'h17,
        64'h1, 1'b0, 17'd0, 17'd0, 64'd12, 1'b1, ST_PROFILE, 64'h0},
      '{CFG_KEEP, 4'h0, 8'h90, 16'h000A, EXT_PROFILE, 16'd5, 4'd0, 8'h17,
        64'h1, 1'b0, 17'd0, 17'd20, 64'd13, 1'b1, ST_OVERRUN, 64'h0},
      // fifteen CSRCs, leading padding, all-ones timestamp at arrival zero
      '{CFG_KEEP, 4'h0, 8'hBF, 16'hFFFF, EXT_PROFILE, 16'd4, 4'd3, 8'h17,
        64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 17'd0, 17'd0, 64'd0,
        1'b1, ST_OK, 64'hFFFF_FFFF_FFFF_FFFF},
      // unknown ID, wrong length, element past the extension end
      '{CFG_KEEP, 4'h0, 8'h90, 16'h000C, EXT_PROFILE, 16'd3, 4'd0, 8'h27,
        64'h55, 1'b0, 17'd0, 17'd0, 64'd14, 1'b1, ST_OK, 64'h0},
      '{CFG_KEEP, 4'h0, 8'h90, 16'h000D, EXT_PROFILE, 16'd3, 4'd0, 8'h13,
        64'h55, 1'b0, 17'd0, 17'd0, 64'd15, 1'b1, ST_OK, 64'h0},
      '{CFG_KEEP, 4'h0, 8'h90, 16'h000E, EXT_PROFILE, 16'd2, 4'd0, 8'h17,
        64'h55, 1'b0, 17'd0, 17'd0, 64'd16, 1'b1, ST_OK, 64'h0},
      // two timestamp elements: the second one counts
      '{CFG_KEEP, 4'h0, 8'h90, 16'h000F, EXT_PROFILE, 16'd5, 4'd0, 8'h17,
        64'h1, 1'b1, 17'd0, 17'd0, 64'd17, 1'b1, ST_OK, 64'hFFFF_FFFF_FFFF_FFFE},
      // zero-length extension
      '{CFG_KEEP, 4'h0, 8'h90, 16'h0010, EXT_PROFILE, 16'd0, 4'd0, 8'h17,
        64'h1, 1'b0, 17'd2, 17'd0, 64'd18, 1'b1, ST_OK, 64'h0},
      // element ID extremes; the spare register write must change nothing
      '{CFG_TS_ID, 4'h0, 8'h90, 16'h0011, EXT_PROFILE, 16'd3, 4'd0, 8'h07,
        64'h8000_0000_0000_0000, 1'b0, 17'd0, 17'd0, 64'd19,
        1'b1, ST_OK, 64'h8000_0000_0000_0000},
      '{CFG_TS_ID, 4'hF, 8'h90, 16'h0012, EXT_PROFILE, 16'd3, 4'd0, 8'hF7,
        64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 17'd0, 17'd0, 64'd20,
        1'b1, ST_OK, 64'h7FFF_FFFF_FFFF_FFFF},
      '{CFG_SPARE, 4'h3, 8'h90, 16'h0013, EXT_PROFILE, 16'd3, 4'd0, 8'hF7,
        64'h5555_5555_5555_5555, 1'b0, 17'd0, 17'd0, 64'd21,
        1'b1, ST_OK, 64'h5555_5555_5555_5555},
      '{CFG_KEEP, 4'h0, 8'h90, 16'h0014, EXT_PROFILE, 16'd3, 4'd0, 8'h17,
        64'h55, 1'b0, 17'd0, 17'd0, 64'd22, 1'b1, ST_OK, 64'h0},
      // back to the reset ID, with a longer payload
      '{CFG_TS_ID, 4'h1, 8'h90, 16'h0015, EXT_PROFILE, 16'd3, 4'd0, 8'h17,
        64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 17'd40, 17'd0, 64'd23, 1'b0, ST_OK, 64'h0},
      '{CFG_KEEP, 4'h0, 8'h90, 16'h0016, EXT_PROFILE, 16'd3, 4'd1, 8'h17,
        64'hDEAD_BEEF_0BAD_F00D, 1'b0, 17'd1, 17'd0, 64'd24, 1'b0, ST_OK, 64'h0}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_access(1'b0, TS_ID_ADDR, '0);
    rnd_bytes = 0;
    for (int r = 0; r < N_DIRECTED; r++) begin
      apply_cfg(directed_pkts[r].cfg_op, directed_pkts[r].cfg_val);
      play_packet(directed_pkts[r]);
      rnd_bytes += pkt_bytes.size();
    end
    rnd_pkts = 0;
    while (rnd_bytes < 950) begin
      if (rnd_pkts % 4 == 0) begin
        op = (rnd_pkts >= 8 && $urandom_range(0, 3) == 0) ? CFG_SPARE : CFG_TS_ID;
        if (rnd_pkts == 0) id_val = 4'h0;
        else if (rnd_pkts == 4) id_val = 4'hF;
        else id_val = 4'($urandom);
        apply_cfg(op, id_val);
      end
      s = random_spec();
      play_packet(s);
      rnd_bytes += pkt_bytes.size();
      rnd_pkts++;
    end
    push <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("rtp_send_timestamp_extractor_tb: clean");
    end else begin
      $display("rtp_send_timestamp_extractor_tb: errors");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("rtp_send_timestamp_extractor_tb: errors");
    $finish;
  end

endmodule
